// File: rtl/raft_leader_election_fsm_macros.svh
// Assertion helpers for the election core; raft_le_back includes them.
`ifndef RAFT_LEADER_ELECTION_FSM_MACROS_SVH
`define RAFT_LEADER_ELECTION_FSM_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define RLE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/raft_le_pkg.sv
// ----------------------------------------------------------------------------
// raft_le_pkg
// Types and constants shared by the election core modules.
// ----------------------------------------------------------------------------
package raft_le_pkg;

    localparam int MODE_W      = 3;
    localparam int MSG_TERM_W  = 32;
    localparam int ID_W        = 4;
    localparam int VOTES_W     = 5;
    localparam int NODE_CNT_W  = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 48;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VOTES_W-1:0] VOTES_MAX = '1;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_ID    = 2'd1;

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_VOTE_REQ     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND_REQ   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ELECT_TMO    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_VOTE_REPLY   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_APPEND_REPLY = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HB_TICK      = 3'd5;

    // Reply kind codes.
    localparam logic [1:0] REPLY_NONE   = 2'd0;
    localparam logic [1:0] REPLY_VOTE   = 2'd1;
    localparam logic [1:0] REPLY_APPEND = 2'd2;

    // Role codes as seen on the result word.
    localparam logic [1:0] ROLE_CODE_FOLLOWER  = 2'd0;
    localparam logic [1:0] ROLE_CODE_CANDIDATE = 2'd1;
    localparam logic [1:0] ROLE_CODE_LEADER    = 2'd2;

    typedef enum logic [2:0] {
        EVT_VOTE_REQ,
        EVT_APPEND_REQ,
        EVT_ELECT_TMO,
        EVT_VOTE_REPLY,
        EVT_APPEND_REPLY,
        EVT_HB_TICK,
        EVT_IDLE
    } evt_t;

    typedef enum logic [2:0] {
        ROLE_FOLLOWER  = 3'b001,
        ROLE_CANDIDATE = 3'b010,
        ROLE_LEADER    = 3'b100
    } role_t;

    typedef struct packed {
        evt_t                  evt;
        logic [MSG_TERM_W-1:0] msg_term;
        logic [MSG_TERM_W-1:0] peer_term;
        logic                  granted;
        logic [ID_W-1:0]       sender_id;
    } item_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_ctl_t;

    function automatic logic [1:0] role_code(input role_t r);
        logic [1:0] c;
        begin
            unique case (r)
                ROLE_FOLLOWER:  c = ROLE_CODE_FOLLOWER;
                ROLE_CANDIDATE: c = ROLE_CODE_CANDIDATE;
                ROLE_LEADER:    c = ROLE_CODE_LEADER;
                default:        c = ROLE_CODE_FOLLOWER;
            endcase
            return c;
        end
    endfunction

endpackage

// File: rtl/raft_leader_election_fsm.sv
// An accepted word is written into the event queue; the back pops it when the
// output register is free and writes its result word into that register.
// Throughput: one event per cycle unless stalled; term update is combinational.
// A two-entry event queue lets input and output stall independently.
// Reset (rst_n low, asynchronous): term 1, follower, no votes, no known leader,
// node_count 3, queue and output register empty.
// ----------------------------------------------------------------------------
// raft_leader_election_fsm
// Raft-style election core: decode front, event queue, election state back.
// ----------------------------------------------------------------------------
module raft_leader_election_fsm
#(
    parameter int MAX_NODES = 16,
    parameter int TERM_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: msg_term[31:0], peer_term[63:32], granted[64], sender_id[68:65], zero pad
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [raft_le_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: mode[2:0]
    input  logic [raft_le_pkg::MODE_W-1:0]       s_tuser,
    // m_tdata: reply_ok[0], term_now[32:1], role_now[34:33], leader_known[35],
    // leader_node[39:36], send_vote_requests[40], send_heartbeats[41],
    // restart_election_timer[42], start_vote_timer[43], stop_heartbeat[44], zero pad
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [raft_le_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: reply_kind[1:0]
    output logic [1:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [raft_le_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [raft_le_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int NW  = (NCW > raft_le_pkg::NODE_CNT_W) ? NCW : raft_le_pkg::NODE_CNT_W;

    logic [NW-1:0]       majority_reg, majority_next;
    logic [NW-1:0]       n_clamp;
    logic                q_full, q_valid, pop;
    raft_le_pkg::q_ctl_t q_ctl;
    raft_le_pkg::item_t  wr_item, rd_item;

    assign cfg_ready = 1'b1;

    // Clamp node_count to the legal range and keep the majority ready for use.
    // node_id is not used by the core, so writes to it are dropped.
    always_comb
    begin
        n_clamp = NW'(cfg_data[raft_le_pkg::NODE_CNT_W-1:0]);
        if (n_clamp < NW'(3))
        begin
            n_clamp = NW'(3);
        end
        else if (n_clamp > NW'(MAX_NODES))
        begin
            n_clamp = NW'(MAX_NODES);
        end
        majority_next = (n_clamp >> 1) + NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            majority_reg <= NW'(2);
        end
        else if (cfg_valid && cfg_index == raft_le_pkg::REG_NODE_COUNT)
        begin
            majority_reg <= majority_next;
        end
    end

    raft_le_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_ctl    (q_ctl),
        .item     (wr_item)
    );

    raft_le_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_ctl    (q_ctl),
        .wr_item  (wr_item),
        .full     (q_full),
        .rd_valid (q_valid),
        .pop      (pop),
        .rd_item  (rd_item)
    );

    raft_le_back
    #(
        .TERM_BITS (TERM_BITS),
        .NW        (NW)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (rd_item),
        .pop      (pop),
        .majority (majority_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/raft_le_front.sv
// ----------------------------------------------------------------------------
// raft_le_front
// Accepts input words, decodes the mode into an event and fills the queue.
// ----------------------------------------------------------------------------
module raft_le_front
(
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [raft_le_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [raft_le_pkg::MODE_W-1:0]     s_tuser,
    input  logic                               q_full,
    output raft_le_pkg::q_ctl_t                q_ctl,
    output raft_le_pkg::item_t                 item
);

    raft_le_pkg::evt_t evt;

    always_comb
    begin
        unique case (s_tuser)
            raft_le_pkg::MODE_VOTE_REQ:     evt = raft_le_pkg::EVT_VOTE_REQ;
            raft_le_pkg::MODE_APPEND_REQ:   evt = raft_le_pkg::EVT_APPEND_REQ;
            raft_le_pkg::MODE_ELECT_TMO:    evt = raft_le_pkg::EVT_ELECT_TMO;
            raft_le_pkg::MODE_VOTE_REPLY:   evt = raft_le_pkg::EVT_VOTE_REPLY;
            raft_le_pkg::MODE_APPEND_REPLY: evt = raft_le_pkg::EVT_APPEND_REPLY;
            raft_le_pkg::MODE_HB_TICK:      evt = raft_le_pkg::EVT_HB_TICK;
            // mode codes 6 and 7 are unused and do nothing
            default:                        evt = raft_le_pkg::EVT_IDLE;
        endcase
    end

    assign s_tready       = !q_full;
    assign q_ctl.push     = s_tvalid && !q_full;
    assign q_ctl.full     = q_full;

    assign item.evt       = evt;
    assign item.msg_term  = s_tdata[31:0];
    assign item.peer_term = s_tdata[63:32];
    assign item.granted   = s_tdata[64];
    assign item.sender_id = s_tdata[68:65];

endmodule

// File: rtl/raft_le_queue.sv
// ----------------------------------------------------------------------------
// raft_le_queue
// Short FIFO of decoded events between the front and the back.
// ----------------------------------------------------------------------------
module raft_le_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  raft_le_pkg::q_ctl_t q_ctl,
    input  raft_le_pkg::item_t  wr_item,
    output logic                full,
    output logic                rd_valid,
    input  logic                pop,
    output raft_le_pkg::item_t  rd_item
);

    localparam int AW = $clog2(raft_le_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(raft_le_pkg::QUEUE_DEPTH + 1);

    raft_le_pkg::item_t mem [raft_le_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (cnt_reg == CW'(raft_le_pkg::QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign do_push  = q_ctl.push && !q_ctl.full;
    assign do_pop   = pop && rd_valid;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(raft_le_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(raft_le_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: rtl/raft_le_back.sv
// ----------------------------------------------------------------------------
// raft_le_back
// Election state: one event per cycle unless stalled; registers the result.
// ----------------------------------------------------------------------------
`include "raft_leader_election_fsm_macros.svh"

module raft_le_back
#(
    parameter int TERM_BITS = 32,
    parameter int NW        = 5
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  raft_le_pkg::item_t                 q_item,
    output logic                               pop,
    input  logic [NW-1:0]                      majority,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [raft_le_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [1:0]                         m_tuser
);

    localparam int XW = (TERM_BITS > raft_le_pkg::MSG_TERM_W) ? TERM_BITS
                                                              : raft_le_pkg::MSG_TERM_W;
    localparam logic [TERM_BITS-1:0] TERM_MAX = '1;

    logic [TERM_BITS-1:0]                term_reg, term_next;
    raft_le_pkg::role_t                  role_reg, role_next;
    logic [raft_le_pkg::VOTES_W-1:0]     votes_reg, votes_next;
    logic                                lvalid_reg, lvalid_next;
    logic [raft_le_pkg::ID_W-1:0]        lidx_reg, lidx_next;

    logic                                out_valid_reg;
    logic [raft_le_pkg::M_TDATA_W-1:0]   out_data_reg, out_data_next;
    logic [1:0]                          out_kind_reg, out_kind_next;

    logic [TERM_BITS-1:0]                mterm;
    logic [TERM_BITS-1:0]                pterm;
    logic [raft_le_pkg::VOTES_W-1:0]     votes_inc;
    logic [1:0]                          rkind;
    logic                                rok, svote, shb, rst_tmr, svt, stop;
    logic [raft_le_pkg::MSG_TERM_W-1:0]  term_out;

    assign pop   = q_valid && (!out_valid_reg || m_tready);
    assign mterm = TERM_BITS'(XW'(q_item.msg_term));
    assign pterm = TERM_BITS'(XW'(q_item.peer_term));
    assign votes_inc = (votes_reg != raft_le_pkg::VOTES_MAX) ? votes_reg + 1'b1 : votes_reg;

    always_comb
    begin
        term_next   = term_reg;
        role_next   = role_reg;
        votes_next  = votes_reg;
        lvalid_next = lvalid_reg;
        lidx_next   = lidx_reg;
        rkind       = raft_le_pkg::REPLY_NONE;
        rok         = 1'b0;
        svote       = 1'b0;
        shb         = 1'b0;
        rst_tmr     = 1'b0;
        svt         = 1'b0;
        stop        = 1'b0;
        unique case (q_item.evt)
            raft_le_pkg::EVT_VOTE_REQ:
            begin
                rkind = raft_le_pkg::REPLY_VOTE;
                rok   = (mterm > term_reg);
            end
            raft_le_pkg::EVT_APPEND_REQ:
            begin
                rkind = raft_le_pkg::REPLY_APPEND;
                if (term_reg <= mterm)
                begin
                    stop        = (role_reg == raft_le_pkg::ROLE_LEADER);
                    role_next   = raft_le_pkg::ROLE_FOLLOWER;
                    term_next   = mterm;
                    lvalid_next = 1'b1;
                    lidx_next   = q_item.sender_id;
                    rst_tmr     = 1'b1;
                    rok         = 1'b1;
                end
            end
            raft_le_pkg::EVT_ELECT_TMO:
            begin
                if (mterm >= term_reg && role_reg != raft_le_pkg::ROLE_LEADER)
                begin
                    role_next  = raft_le_pkg::ROLE_CANDIDATE;
                    // saturate the term at its largest value
                    term_next  = (term_reg != TERM_MAX) ? term_reg + 1'b1 : term_reg;
                    votes_next = raft_le_pkg::VOTES_W'(1);
                    svote      = 1'b1;
                    svt        = 1'b1;
                end
            end
            raft_le_pkg::EVT_VOTE_REPLY:
            begin
                if (mterm == term_reg && role_reg == raft_le_pkg::ROLE_CANDIDATE
                    && q_item.granted)
                begin
                    votes_next = votes_inc;
                    if (NW'(votes_inc) >= majority)
                    begin
                        role_next = raft_le_pkg::ROLE_LEADER;
                        shb       = 1'b1;
                    end
                end
            end
            raft_le_pkg::EVT_APPEND_REPLY:
            begin
                if (mterm == term_reg && pterm > term_reg)
                begin
                    stop      = (role_reg == raft_le_pkg::ROLE_LEADER);
                    role_next = raft_le_pkg::ROLE_FOLLOWER;
                    term_next = pterm;
                    rst_tmr   = 1'b1;
                end
            end
            raft_le_pkg::EVT_HB_TICK:
            begin
                shb = (mterm == term_reg && role_reg == raft_le_pkg::ROLE_LEADER);
            end
            default:
            begin
                rkind = raft_le_pkg::REPLY_NONE;
            end
        endcase
    end

    assign term_out      = raft_le_pkg::MSG_TERM_W'(XW'(term_next));
    assign out_kind_next = rkind;
    assign out_data_next = {3'b000, stop, svt, rst_tmr, shb, svote, lidx_next, lvalid_next,
                            raft_le_pkg::role_code(role_next), term_out, rok};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg      <= TERM_BITS'(1);
            role_reg      <= raft_le_pkg::ROLE_FOLLOWER;
            votes_reg     <= '0;
            lvalid_reg    <= 1'b0;
            lidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                term_reg   <= term_next;
                role_reg   <= role_next;
                votes_reg  <= votes_next;
                lvalid_reg <= lvalid_next;
                lidx_reg   <= lidx_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= out_kind_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    `RLE_ASSERT(a_stop_as_follower,
                (m_tvalid && m_tdata[44]) |-> (m_tdata[34:33] == raft_le_pkg::ROLE_CODE_FOLLOWER),
                "stop_heartbeat raised without stepping down")
    `RLE_ASSERT(a_hb_as_leader,
                (m_tvalid && m_tdata[41]) |-> (m_tdata[34:33] == raft_le_pkg::ROLE_CODE_LEADER),
                "heartbeats sent while not leader")
    `RLE_ASSERT(a_term_monotonic, pop |=> (term_reg >= $past(term_reg)),
                "term moved backward")
    `RLE_NEVER(a_vote_req_role,
               m_tvalid && m_tdata[40] && (m_tdata[34:33] != raft_le_pkg::ROLE_CODE_CANDIDATE),
               "vote requests sent outside a candidacy")

endmodule
